// File: sv/hmp_pkg.sv
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared types, constants and helpers for the hash message padder.
// ----------------------------------------------------------------------------
`default_nettype none

package hmp_pkg;

	// Message padding constants
	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam int         COUNT_W       = 61;
	localparam int         HOLD_W        = 56;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	// Request type codes
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Length byte order codes
	localparam logic ORDER_LE = 1'b0;
	localparam logic ORDER_BE = 1'b1;

	// Datapath operations issued by the controller
	typedef enum logic [2:0] {
		OP_NONE,
		OP_BYTE,
		OP_FIRST,
		OP_ZERO,
		OP_LEN
	} hmp_op_t;

	typedef struct packed {
		hmp_op_t op;
	} hmp_cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [2:0] word_idx;
	} hmp_status_t;

	// Reverse the byte order of a 64-bit word
	function automatic logic [63:0] bswap64(input logic [63:0] w);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = w[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/hmp_intf.sv
// ----------------------------------------------------------------------------
// hmp_intf
// Valid/ready channels of the hash message padder: request, word, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmp_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] data_byte;

	modport source (output valid, output req_type, output data_byte, input ready);
	modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface hmp_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_word;
	logic        last_word;

	modport source (output valid, output out_word, output last_word, input ready);
	modport sink   (input valid, input out_word, input last_word, output ready);
endinterface

interface hmp_cfg_if;
	logic valid;
	logic ready;
	logic length_order;

	modport source (output valid, output length_order, input ready);
	modport sink   (input valid, input length_order, output ready);
endinterface

`default_nettype wire

// File: sv/hmp_datapath.sv
// ----------------------------------------------------------------------------
// hmp_datapath
// Byte counter, byte packing hold, length formatting and output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmp_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  hmp_pkg::hmp_cmd_t    cmd,
	input  wire [7:0]            data_byte,
	input  wire                  cfg_valid,
	input  wire                  cfg_order,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [63:0]          out_word,
	output logic                 last_word,
	output hmp_pkg::hmp_status_t status
);
	import hmp_pkg::*;

	logic [COUNT_W-1:0] byte_count_q;
	logic [HOLD_W-1:0]  hold_q;
	logic               order_q;
	logic [63:0]        word_q;
	logic               last_q;
	logic               valid_q;

	logic [2:0]  hold_pos;
	logic [5:0]  hold_shift;
	logic [63:0] bit_len;
	logic [63:0] next_word;
	logic        load_word;

	assign hold_pos   = byte_count_q[2:0];
	assign hold_shift = {hold_pos, 3'b000};
	assign bit_len    = {byte_count_q, 3'b000};

	// Word to emit for the current operation
	always_comb begin
		next_word = '0;
		load_word = 1'b0;
		case (cmd.op)
			OP_BYTE: begin
				next_word = {data_byte, hold_q};
				load_word = (hold_pos == LAST_WORD_IDX);
			end
			OP_FIRST: begin
				next_word = {8'h00, hold_q} | ({56'd0, PAD_BYTE} << hold_shift);
				load_word = 1'b1;
			end
			OP_ZERO: begin
				next_word = '0;
				load_word = 1'b1;
			end
			OP_LEN: begin
				next_word = (order_q == ORDER_BE) ? bswap64(bit_len) : bit_len;
				load_word = 1'b1;
			end
			default: begin
				next_word = '0;
				load_word = 1'b0;
			end
		endcase
	end

	// Message state: count and packing hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			hold_q       <= '0;
		end else begin
			case (cmd.op)
				OP_BYTE: begin
					byte_count_q <= byte_count_q + 1'b1;
					if (hold_pos == LAST_WORD_IDX) begin
						hold_q <= '0;
					end else begin
						hold_q[hold_shift +: 8] <= data_byte;
					end
				end
				OP_FIRST: begin
					hold_q <= '0;
				end
				OP_LEN: begin
					byte_count_q <= '0;
					hold_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Length byte order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_LE;
		end else if (cfg_valid) begin
			order_q <= cfg_order;
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_word) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_word) begin
			word_q <= next_word;
			last_q <= (cmd.op == OP_LEN);
		end
	end

	assign out_valid       = valid_q;
	assign out_word        = word_q;
	assign last_word       = last_q;
	assign status.out_free = !valid_q || out_ready;
	assign status.word_idx = byte_count_q[5:3];

	// A word is only loaded into a free output slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_word |-> (!valid_q || out_ready))
		else $error("word loaded while output slot busy");

	// The length word ends the message and leaves cleared state
	a_len_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LEN) |=> (byte_count_q == '0 && hold_q == '0 && last_q))
		else $error("state not cleared after length word");

	// The packing hold is empty whenever the fill position is zero
	a_hold_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(hold_pos == 3'd0) |-> (hold_q == '0))
		else $error("stale bytes in packing hold");

endmodule

`default_nettype wire

// File: sv/hmp_ctrl.sv
// ----------------------------------------------------------------------------
// hmp_ctrl
// Controller: accepts items and sequences the padding words of a message end.
// ----------------------------------------------------------------------------
`default_nettype none

module hmp_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_req_type,
	input  hmp_pkg::hmp_status_t status,
	output logic                 in_ready,
	output hmp_pkg::hmp_cmd_t    cmd
);
	import hmp_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_PAD
	} state_t;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic [3:0] pad_words;

	// Words left after the first padding word: length lands in word 7 of
	// this block, or of the next one when the 0x80 falls in word 7
	assign pad_words = (status.word_idx == LAST_WORD_IDX) ? 4'd8
		: (4'd7 - {1'b0, status.word_idx});

	assign in_ready = (state_q == S_IDLE) && status.out_free;

	// Command decode
	always_comb begin
		cmd.op = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.op = (in_req_type == REQ_END) ? OP_FIRST : OP_BYTE;
				end
			end
			S_PAD: begin
				if (status.out_free) begin
					cmd.op = (cnt_q == 4'd1) ? OP_LEN : OP_ZERO;
				end
			end
			default: begin
				cmd.op = OP_NONE;
			end
		endcase
	end

	// State and word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.op == OP_FIRST) begin
						state_q <= S_PAD;
						cnt_q   <= pad_words;
					end
				end
				S_PAD: begin
					if (status.out_free) begin
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == 4'd1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Padding count stays within one to eight words
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD) |-> (cnt_q != 4'd0 && cnt_q <= 4'd8))
		else $error("padding word count out of range");

	// Emitting the length word returns to idle
	a_len_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LEN) |=> (state_q == S_IDLE))
		else $error("controller did not return to idle");

	// An end marker always starts a padding sequence
	a_end_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_FIRST) |=> (state_q == S_PAD))
		else $error("end marker did not start padding");

endmodule

`default_nettype wire

// File: sv/hash_message_padder_core.sv
// ----------------------------------------------------------------------------
// hash_message_padder_core
// Merkle-Damgard padder for MD5 / SHA-256: packs bytes into 64-bit words.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while idle with the output register
// free, and packed into 64-bit words, earliest byte in bits 7:0; a full word
// goes to the single output register. An end marker appends 0x80, zero bytes
// up to 56 mod 64 and the 64-bit bit length (little-endian when length_order
// is 0, big-endian when 1), and emits 2 to 9 words, one per cycle while the
// output register is free, the last flagged by last_word. No new item is taken
// until the final word is loaded. The user must write length_order only while
// the block is idle, not enforced by the block; the config channel is always ready.
`default_nettype none

module hash_message_padder_core (
	input  wire        clk,
	input  wire        arst_n,
	hmp_req_if.sink    req,
	hmp_word_if.source rsp,
	hmp_cfg_if.sink    cfg
);
	import hmp_pkg::*;

	hmp_cmd_t    cmd;
	hmp_status_t status;

	assign cfg.ready = 1'b1;

	// Control
	hmp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.status      (status),
		.in_ready    (req.ready),
		.cmd         (cmd)
	);

	// Datapath
	hmp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (req.data_byte),
		.cfg_valid (cfg.valid),
		.cfg_order (cfg.length_order),
		.out_ready (rsp.ready),
		.out_valid (rsp.valid),
		.out_word  (rsp.out_word),
		.last_word (rsp.last_word),
		.status    (status)
	);

endmodule

`default_nettype wire
